@@ rtl/ppmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Shared types, constants and control bundles of the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

  // Channels in one PPM frame
  localparam int CHANNELS = 8;
  // Width of the channel count and the emit index
  localparam int CNT_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed field widths
  localparam int TIME_W   = 32;
  localparam int WIDTH_W  = 16;
  localparam int IDX_W    = 3;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 2'd2;

  // Configuration reset values
  localparam logic [WIDTH_W-1:0] SYNC_MIN_RST  = 16'd2200;
  localparam logic [WIDTH_W-1:0] PULSE_MIN_RST = 16'd900;
  localparam logic [WIDTH_W-1:0] PULSE_MAX_RST = 16'd2100;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_IGNORED = 3'd0,
    KIND_SYNC    = 3'd1,
    KIND_STORED  = 3'd2,
    KIND_LOST    = 3'd3,
    KIND_FRAME   = 3'd4
  } kind_t;

  // State updates requested of the datapath
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ARM,
    ACT_RESYNC,
    ACT_STORE,
    ACT_LOSE
  } act_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  capture;   // take the edge time, form the interval
    logic  load;      // load the output register
    kind_t kind;      // kind of the loaded result
    logic  sel_store; // result comes from the channel store
    logic  emit_step; // advance the emit index
    act_t  act;       // decoder state update
  } ppmfd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic synced;
    logic ge_sync;
    logic in_window;
    logic count_full;
    logic emit_last;
    logic out_free;
  } ppmfd_sts_t;

endpackage

@@ rtl/ppm_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// RC PPM decoder: classifies edge intervals and emits stored channel frames.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata[31:0] edge_time_us
// m_*      out  m_tvalid/m_tready  tdata, tuser event_kind, tlast last
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data[15:0]
//
// An edge passes the capture and classify states and yields one result; the
// edge completing a frame yields CHANNELS frame results, the emit index
// reading one stored channel per cycle into the output register when free.
// Reset is synchronous; the channel store is not cleared.
// A stalled m_tready holds the output register and the sequencer waits on it.
// ----------------------------------------------------------------------------
module ppm_frame_decoder import ppmfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // tdata: edge_time_us[31:0]
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TIME_W-1:0]    s_tdata,
  // tdata: channel_index[2:0], channel_width_us[18:3], update_flag[19], zeros
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,
  // tuser: event_kind[2:0]
  output logic [KIND_W-1:0]    m_tuser,
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data
);

  ppmfd_cmd_t         cmd;
  ppmfd_sts_t         sts;
  logic [IDX_W-1:0]   channel_index;
  logic [WIDTH_W-1:0] channel_width_us;
  logic               update_flag;

  assign cfg_ready = 1'b1;

  // Sequencer
  ppmfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  ppmfd_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .edge_time_us     (s_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .m_tready         (m_tready),
    .m_tvalid         (m_tvalid),
    .event_kind       (m_tuser),
    .channel_index    (channel_index),
    .channel_width_us (channel_width_us),
    .update_flag      (update_flag),
    .last             (m_tlast),
    .cmd              (cmd),
    .sts              (sts)
  );

  // Pack result fields
  assign m_tdata = {4'b0000, update_flag, channel_width_us, channel_index};

endmodule

@@ rtl/ppmfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppmfd_ctrl
// Sequencer: accepts an edge, classifies its interval, emits the results.
// ----------------------------------------------------------------------------
module ppmfd_ctrl import ppmfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  ppmfd_sts_t sts,
  output ppmfd_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  // Decode commands for the current state
  always_comb begin
    cmd        = '0;
    cmd.kind   = KIND_IGNORED;
    cmd.act    = ACT_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          priority if (!sts.synced) begin
            cmd.load = 1'b1;
            if (sts.ge_sync) begin
              cmd.kind = KIND_SYNC;
              cmd.act  = ACT_ARM;
            end else begin
              cmd.kind = KIND_IGNORED;
            end
          end else if (sts.ge_sync) begin
            cmd.load = 1'b1;
            cmd.kind = KIND_SYNC;
            cmd.act  = ACT_RESYNC;
          end else if (sts.in_window) begin
            cmd.act = ACT_STORE;
            if (sts.count_full) begin
              state_next = S_EMIT;
            end else begin
              cmd.load = 1'b1;
              cmd.kind = KIND_STORED;
            end
          end else begin
            cmd.load = 1'b1;
            cmd.kind = KIND_LOST;
            cmd.act  = ACT_LOSE;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load      = 1'b1;
          cmd.kind      = KIND_FRAME;
          cmd.sel_store = 1'b1;
          cmd.emit_step = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Never overwrite a result that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result loaded over a pending one");
`endif

endmodule

@@ rtl/ppmfd_datapath.sv @@
// ----------------------------------------------------------------------------
// ppmfd_datapath
// Interval, decoder state, channel store, configuration and output register.
// ----------------------------------------------------------------------------
module ppmfd_datapath import ppmfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [TIME_W-1:0]    edge_time_us,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data,
  input  logic                 m_tready,
  output logic                 m_tvalid,
  output logic [KIND_W-1:0]    event_kind,
  output logic [IDX_W-1:0]     channel_index,
  output logic [WIDTH_W-1:0]   channel_width_us,
  output logic                 update_flag,
  output logic                 last,
  input  ppmfd_cmd_t           cmd,
  output ppmfd_sts_t           sts
);

  logic [WIDTH_W-1:0] sync_min;
  logic [WIDTH_W-1:0] pulse_min;
  logic [WIDTH_W-1:0] pulse_max;

  logic [TIME_W-1:0]  prev_time;
  logic [TIME_W-1:0]  diff;
  logic [WIDTH_W-1:0] delta;
  logic               synced;
  logic [CNT_W-1:0]   count;
  logic               marker;
  logic               marker_next;
  logic [CNT_W-1:0]   emit_idx;
  logic [WIDTH_W-1:0] store [CHANNELS];
  logic               count_full;
  logic               emit_last;

  logic               out_valid;
  kind_t              out_kind;

  assign diff       = edge_time_us - prev_time;
  assign count_full = (count == CNT_W'(CHANNELS - 1));
  assign emit_last  = (emit_idx == CNT_W'(CHANNELS - 1));

  // Status for the sequencer
  assign sts.synced     = synced;
  assign sts.ge_sync    = (delta >= sync_min);
  assign sts.in_window  = (delta >= pulse_min) && (delta <= pulse_max);
  assign sts.count_full = count_full;
  assign sts.emit_last  = emit_last;
  assign sts.out_free   = !out_valid || m_tready;

  // Update marker after this event
  always_comb begin
    unique case (cmd.act)
      ACT_ARM:    marker_next = 1'b0;
      ACT_RESYNC: marker_next = 1'b1;
      default:    marker_next = marker;
    endcase
  end

  // Configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min  <= SYNC_MIN_RST;
      pulse_min <= PULSE_MIN_RST;
      pulse_max <= PULSE_MAX_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SYNC_MIN)  sync_min  <= cfg_data;
      if (cfg_index == REG_PULSE_MIN) pulse_min <= cfg_data;
      if (cfg_index == REG_PULSE_MAX) pulse_max <= cfg_data;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      synced    <= 1'b0;
      count     <= '0;
      marker    <= 1'b0;
      emit_idx  <= '0;
    end else begin
      if (cmd.capture) begin
        prev_time <= edge_time_us;
      end
      marker <= marker_next;
      unique case (cmd.act)
        ACT_ARM: begin
          synced <= 1'b1;
          count  <= '0;
        end
        ACT_RESYNC: count <= '0;
        ACT_STORE:  count <= count_full ? '0 : count + 1'b1;
        ACT_LOSE:   synced <= 1'b0;
        default: ;
      endcase
      if (cmd.emit_step) begin
        emit_idx <= emit_last ? '0 : emit_idx + 1'b1;
      end
    end
  end

  // Interval and channel store
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      delta <= diff[WIDTH_W-1:0];
    end
    if (cmd.act == ACT_STORE) begin
      store[count] <= delta;
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind    <= cmd.kind;
      update_flag <= marker_next;
      last        <= !cmd.sel_store || emit_last;
      if (cmd.sel_store) begin
        channel_index    <= IDX_W'(emit_idx);
        channel_width_us <= store[emit_idx];
      end else begin
        channel_index    <= (cmd.act == ACT_STORE) ? IDX_W'(count) : '0;
        channel_width_us <= delta;
      end
    end
  end

  assign m_tvalid   = out_valid;
  assign event_kind = out_kind;

`ifndef NO_ASSERTIONS
  // Channels are stored only while armed
  a_store_synced: assert property (@(posedge clk) disable iff (rst)
    (cmd.act == ACT_STORE) |-> synced)
    else $error("channel stored while not synced");

  // A frame is emitted only after the count restarted
  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |-> (count == '0))
    else $error("frame emitted with channels pending");

  // Arming clears count and update marker
  a_arm_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(synced) |-> (!marker && (count == '0)))
    else $error("arming left stale count or marker");
`endif

endmodule
